// ----- hw/rtl/alkf_pkg.sv -----
// Shared types, constants and helpers for the joystick ladder key filter.
`timescale 1ns / 1ps

package alkf_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned KEY_W = 3;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned NUM_THR = 5;
  localparam int unsigned AVG_DEPTH_DEFAULT = 8;

  typedef enum logic [KEY_W-1:0] {
    BTN_NONE   = 3'd0,
    BTN_UP     = 3'd1,
    BTN_DOWN   = 3'd2,
    BTN_LEFT   = 3'd3,
    BTN_RIGHT  = 3'd4,
    BTN_SELECT = 3'd5
  } key_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RIGHT_UPPER   = 3'd0,
    REG_UP_UPPER      = 3'd1,
    REG_SELECT_UPPER  = 3'd2,
    REG_LEFT_UPPER    = 3'd3,
    REG_DOWN_UPPER    = 3'd4,
    REG_DEAD_BAND     = 3'd5,
    REG_CONFIRM_COUNT = 3'd6
  } reg_idx_e;

  localparam logic [SAMPLE_W-1:0] RIGHT_UPPER_RST  = 10'd78;
  localparam logic [SAMPLE_W-1:0] UP_UPPER_RST     = 10'd188;
  localparam logic [SAMPLE_W-1:0] SELECT_UPPER_RST = 10'd403;
  localparam logic [SAMPLE_W-1:0] LEFT_UPPER_RST   = 10'd620;
  localparam logic [SAMPLE_W-1:0] DOWN_UPPER_RST   = 10'd950;
  localparam logic [SAMPLE_W-1:0] DEAD_BAND_RST    = 10'd10;
  localparam logic [COUNT_W-1:0]  CONFIRM_RST      = 8'd3;

  typedef struct packed {
    logic [NUM_THR-1:0][SAMPLE_W-1:0] thr;
    logic [SAMPLE_W-1:0]              dead_band;
    logic [COUNT_W-1:0]               confirm;
  } cfg_t;

  // Threshold indices 0 to 4 map to right, up, select, left, down in that order.
  function automatic key_e band_key(input logic [2:0] idx);
    key_e k;
    case (idx)
      3'd0:    k = BTN_RIGHT;
      3'd1:    k = BTN_UP;
      3'd2:    k = BTN_SELECT;
      3'd3:    k = BTN_LEFT;
      3'd4:    k = BTN_DOWN;
      default: k = BTN_NONE;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/adc_ladder_key_filter_top.sv -----
// Top level of the joystick ladder key filter.
//
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    sample_i
// out      output     out_valid_o / out_ready_i  conf_key_o, raw_class_o, mean_level_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One sample can transfer per cycle while the output is not stalled; its running total is
// held in the input register and its result is then loaded into the output register.
// The running total is updated at the input register, and the mean divide, band
// compare and debounce counter run between that register and the output register.
// Reset empties both stages; the first sample then fills the averaging window.
// A stalled output holds the input stage, which in turn drops in_ready_o.
`timescale 1ns / 1ps

module adc_ladder_key_filter_top #(
  parameter int unsigned AVG_DEPTH = alkf_pkg::AVG_DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [alkf_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [alkf_pkg::KEY_W-1:0]      conf_key_o,
  output logic [alkf_pkg::KEY_W-1:0]      raw_class_o,
  output logic [alkf_pkg::SAMPLE_W-1:0]   mean_level_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [alkf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [alkf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned TOT_W = alkf_pkg::SAMPLE_W + $clog2(AVG_DEPTH);

  alkf_pkg::cfg_t   cfg;
  logic             adv;
  logic             stage_valid;
  logic [TOT_W-1:0] total;

  alkf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  alkf_ring #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .adv_i         (adv),
    .stage_valid_o (stage_valid),
    .total_o       (total)
  );

  alkf_classify #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .stage_valid_i (stage_valid),
    .total_i       (total),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .conf_key_o    (conf_key_o),
    .raw_class_o   (raw_class_o),
    .mean_level_o  (mean_level_o)
  );

endmodule

// ----- hw/rtl/alkf_cfg.sv -----
// Configuration register file for thresholds, dead band and confirm count.
`timescale 1ns / 1ps

module alkf_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [alkf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [alkf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output alkf_pkg::cfg_t                   cfg_o
);

  alkf_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr[0]    <= alkf_pkg::RIGHT_UPPER_RST;
      cfg_q.thr[1]    <= alkf_pkg::UP_UPPER_RST;
      cfg_q.thr[2]    <= alkf_pkg::SELECT_UPPER_RST;
      cfg_q.thr[3]    <= alkf_pkg::LEFT_UPPER_RST;
      cfg_q.thr[4]    <= alkf_pkg::DOWN_UPPER_RST;
      cfg_q.dead_band <= alkf_pkg::DEAD_BAND_RST;
      cfg_q.confirm   <= alkf_pkg::CONFIRM_RST;
    end else if (cfg_valid_i) begin
      unique case (alkf_pkg::reg_idx_e'(cfg_index_i))
        alkf_pkg::REG_RIGHT_UPPER:   cfg_q.thr[0] <= cfg_data_i;
        alkf_pkg::REG_UP_UPPER:      cfg_q.thr[1] <= cfg_data_i;
        alkf_pkg::REG_SELECT_UPPER:  cfg_q.thr[2] <= cfg_data_i;
        alkf_pkg::REG_LEFT_UPPER:    cfg_q.thr[3] <= cfg_data_i;
        alkf_pkg::REG_DOWN_UPPER:    cfg_q.thr[4] <= cfg_data_i;
        alkf_pkg::REG_DEAD_BAND:     cfg_q.dead_band <= cfg_data_i;
        alkf_pkg::REG_CONFIRM_COUNT: cfg_q.confirm <= cfg_data_i[alkf_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/alkf_ring.sv -----
// Input stage: sample shift line, running total and priming on the first sample.
`timescale 1ns / 1ps

module alkf_ring #(
  parameter int unsigned AVG_DEPTH = alkf_pkg::AVG_DEPTH_DEFAULT,
  localparam int unsigned TOT_W = alkf_pkg::SAMPLE_W + $clog2(AVG_DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [alkf_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                           adv_i,
  output logic                           stage_valid_o,
  output logic [TOT_W-1:0]               total_o
);

  logic [alkf_pkg::SAMPLE_W-1:0] ring_q [AVG_DEPTH];
  logic [TOT_W-1:0]              total_q, total_d;
  logic                          primed_q;
  logic                          stage_valid_q;
  logic                          accept;

  assign in_ready_o    = !stage_valid_q || adv_i;
  assign accept        = in_valid_i && in_ready_o;
  assign stage_valid_o = stage_valid_q;
  assign total_o       = total_q;

  always_comb begin
    if (primed_q) begin
      total_d = total_q - TOT_W'(ring_q[AVG_DEPTH-1]) + TOT_W'(sample_i);
    end else begin
      total_d = TOT_W'(TOT_W'(sample_i) * TOT_W'(AVG_DEPTH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!primed_q) begin
        for (int i = 0; i < AVG_DEPTH; i++) begin
          ring_q[i] <= sample_i;
        end
      end else begin
        ring_q[0] <= sample_i;
        for (int i = 1; i < AVG_DEPTH; i++) begin
          ring_q[i] <= ring_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q       <= '0;
      primed_q      <= 1'b0;
      stage_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        total_q  <= total_d;
        primed_q <= 1'b1;
      end
      if (accept) begin
        stage_valid_q <= 1'b1;
      end else if (adv_i) begin
        stage_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/alkf_classify.sv -----
// Result stage: mean, band classification with dead band hold, debounce and output register.
`timescale 1ns / 1ps

module alkf_classify #(
  parameter int unsigned AVG_DEPTH = alkf_pkg::AVG_DEPTH_DEFAULT,
  localparam int unsigned TOT_W = alkf_pkg::SAMPLE_W + $clog2(AVG_DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  alkf_pkg::cfg_t                 cfg_i,
  input  logic                           stage_valid_i,
  input  logic [TOT_W-1:0]               total_i,
  output logic                           adv_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [alkf_pkg::KEY_W-1:0]     conf_key_o,
  output logic [alkf_pkg::KEY_W-1:0]     raw_class_o,
  output logic [alkf_pkg::SAMPLE_W-1:0]  mean_level_o
);

  localparam int unsigned SHIFT = TOT_W + $clog2(AVG_DEPTH);
  localparam int unsigned RW = TOT_W + 1;
  localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam int unsigned PW = TOT_W + RW;

  logic [PW-1:0]                 prod;
  logic [alkf_pkg::SAMPLE_W-1:0] mean;
  alkf_pkg::key_e                cur, cls;
  logic                          near;
  logic [alkf_pkg::SAMPLE_W-1:0] gap;
  alkf_pkg::key_e                held_q, conf_q, conf_d;
  logic [alkf_pkg::COUNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic                          out_valid_q;
  logic [alkf_pkg::KEY_W-1:0]    stable_q, raw_q;
  logic [alkf_pkg::SAMPLE_W-1:0] mean_q;

  assign adv_o = stage_valid_i && (!out_valid_q || out_ready_i);

  assign prod = PW'(total_i) * PW'(RW'(RECIP));
  assign mean = prod[SHIFT +: alkf_pkg::SAMPLE_W];

  always_comb begin
    cur  = alkf_pkg::BTN_NONE;
    near = 1'b0;
    gap  = '0;
    for (int i = alkf_pkg::NUM_THR - 1; i >= 0; i--) begin
      if (mean < cfg_i.thr[i]) begin
        cur = alkf_pkg::band_key(3'(i));
      end
    end
    for (int i = 0; i < alkf_pkg::NUM_THR; i++) begin
      gap = (mean >= cfg_i.thr[i]) ? (mean - cfg_i.thr[i]) : (cfg_i.thr[i] - mean);
      if (gap < cfg_i.dead_band) begin
        near = 1'b1;
      end
    end
    cls = (cur != held_q && near) ? held_q : cur;
  end

  always_comb begin
    cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
    conf_d  = conf_q;
    cnt_d   = '0;
    if (cls != conf_q) begin
      if (cnt_inc >= cfg_i.confirm) begin
        conf_d = cls;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= alkf_pkg::BTN_NONE;
      conf_q      <= alkf_pkg::BTN_NONE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_o) begin
        held_q      <= cls;
        conf_q      <= conf_d;
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      stable_q <= conf_d;
      raw_q    <= cls;
      mean_q   <= mean;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign conf_key_o   = stable_q;
  assign raw_class_o  = raw_q;
  assign mean_level_o = mean_q;

endmodule

// ----- hw/rtl/alkf_checker.sv -----
// Port-level assertions for the key filter and the bind that attaches them.
`timescale 1ns / 1ps

module alkf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [alkf_pkg::KEY_W-1:0]      conf_key_o,
  input logic [alkf_pkg::KEY_W-1:0]      raw_class_o,
  input logic [alkf_pkg::SAMPLE_W-1:0]   mean_level_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);

  localparam logic [alkf_pkg::KEY_W-1:0] KEY_MAX = alkf_pkg::BTN_SELECT;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(conf_key_o)
      && $stable(raw_class_o) && $stable(mean_level_o))
    else $error("Stalled result changed before its transfer.");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled while the output was free.");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> conf_key_o <= KEY_MAX && raw_class_o <= KEY_MAX)
    else $error("Result carries an undefined key code.");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("Result withdrawn without a transfer.");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("Configuration write not taken.");

endmodule

bind adc_ladder_key_filter_top alkf_checker u_alkf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .conf_key_o   (conf_key_o),
  .raw_class_o  (raw_class_o),
  .mean_level_o (mean_level_o),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o)
);
